// ===== rtl/core/vna_pkg.sv =====
// Shared types, constants and helpers of the vertex normal accumulator.
package vna_pkg;

    localparam int MAX_VERTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_VERTS);
    localparam int IDX_W     = 10;
    localparam int POS_W     = 16;
    localparam int ACC_W     = 40;
    localparam int N_W       = 35;
    localparam int OUT_W     = 16;
    localparam int VREC_W    = 3 * POS_W + 1;
    localparam int AREC_W    = 3 * ACC_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);
    localparam int ONE_Q14   = 16384;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FACE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // One queued request, with the range checks of its indices done
    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        ia;
        logic [IDX_W-1:0]        ib;
        logic [IDX_W-1:0]        ic;
        logic                    ok_a;
        logic                    ok_b;
        logic                    ok_c;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_req;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < MAX_VERTS);
    endfunction

    // Add a face normal component to an accumulator, saturating at ACC_W bits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [N_W-1:0]   b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== rtl/core/vertex_normal_accumulator.sv =====
// Reads of a non-zero normal run the normalizer: the one-bit-a-cycle shift, the 32-step root
// and three divides. A face with an unloaded corner ends early with a drop status, and a read
// of a zero normal skips the normalizer. One item runs in the back end at a time and the next
// starts in the strobe cycle; a two-entry queue takes start meanwhile, busy when full. Reset:
// synchronous; a pass over all 1024 entries clears the vertex memory before queued requests
// run. The receiver cannot stall.
module vertex_normal_accumulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [1:0]                       i_op,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_a,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_b,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_c,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_z,
    output logic                             busy,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_z
);

    vna_pkg::t_req req;
    logic          req_valid;
    logic          pop;

    vna_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_op        (i_op),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_index_c   (i_index_c),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .busy        (busy),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_pop       (pop)
    );

    vna_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_norm_x    (o_norm_x),
        .o_norm_y    (o_norm_y),
        .o_norm_z    (o_norm_z)
    );

endmodule

// ===== rtl/core/vna_front.sv =====
// Front end: accepts requests, range-checks indices and queues them.
module vna_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [1:0]                       i_op,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_a,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_b,
    input  logic [vna_pkg::IDX_W-1:0]        i_index_c,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [vna_pkg::POS_W-1:0] i_pos_z,
    output logic                             busy,
    output vna_pkg::t_req                    o_req,
    output logic                             o_req_valid,
    input  logic                             i_pop
);

    vna_pkg::t_req                r_q [vna_pkg::Q_DEPTH];
    logic [vna_pkg::Q_PW-1:0]     r_wp;
    logic [vna_pkg::Q_PW-1:0]     r_rp;
    logic [vna_pkg::Q_CW-1:0]     r_cnt;
    vna_pkg::t_req                req;
    logic                         push;

    // Classify the incoming request
    always_comb begin
        req.op   = i_op;
        req.ia   = i_index_a;
        req.ib   = i_index_b;
        req.ic   = i_index_c;
        req.ok_a = vna_pkg::in_range(i_index_a);
        req.ok_b = vna_pkg::in_range(i_index_b);
        req.ok_c = vna_pkg::in_range(i_index_c);
        req.x    = i_pos_x;
        req.y    = i_pos_y;
        req.z    = i_pos_z;
    end

    assign busy        = (r_cnt == vna_pkg::Q_CW'(vna_pkg::Q_DEPTH));
    assign push        = start && !busy;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + vna_pkg::Q_CW'(push) - vna_pkg::Q_CW'(i_pop);
        end
    end

    // Hold queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req;
        end
    end

endmodule

// ===== rtl/core/vna_norm.sv =====
// Normalizer: scales an accumulated normal to unit length in Q1.14.
module vna_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [vna_pkg::ACC_W-1:0] i_acc_x,
    input  logic signed [vna_pkg::ACC_W-1:0] i_acc_y,
    input  logic signed [vna_pkg::ACC_W-1:0] i_acc_z,
    output logic                             o_done,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_z
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DSET  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    localparam int AW = vna_pkg::ACC_W;

    logic [2:0]                       r_state;
    logic [1:0]                       r_k;
    logic [3:0]                       r_i;
    logic [AW-1:0]                    r_mag [3];
    logic [2:0]                       r_neg;
    logic [61:0]                      r_sum;
    logic [61:0]                      r_rad;
    logic [62:0]                      r_res;
    logic [62:0]                      r_bit;
    logic [46:0]                      r_rem;
    logic [47:0]                      r_dsh;
    logic [15:0]                      r_q;
    logic signed [vna_pkg::OUT_W-1:0] r_out [3];
    logic                             r_done;

    logic [AW-1:0] m;
    logic [59:0]   sq;
    logic [63:0]   trial;
    logic          ge;
    logic [15:0]   qn;
    logic [15:0]   qc;

    // Largest magnitude, one square, one root trial, one divide trial
    always_comb begin
        m = r_mag[0];
        if (r_mag[1] > m) begin
            m = r_mag[1];
        end
        if (r_mag[2] > m) begin
            m = r_mag[2];
        end
        sq    = r_mag[r_k][29:0] * r_mag[r_k][29:0];
        trial = {1'b0, r_res} + {1'b0, r_bit};
        ge    = ({1'b0, r_rem} >= r_dsh);
        qn    = r_q | (ge ? (16'd1 << r_i) : 16'd0);
        qc    = (32'(qn) > vna_pkg::ONE_Q14) ? 16'(vna_pkg::ONE_Q14) : qn;
    end

    // Control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if ((m[AW-1:30] == '0) && m[29]) begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_k == 2'd2) begin
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (r_i == 4'd0) begin
                        if (r_k == 2'd2) begin
                            r_state <= N_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= N_DSET;
                        end
                    end
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    // Datapath: shift to bit 29, sum squares, root, then divide per component
    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                r_mag[0] <= i_acc_x[AW-1] ? AW'(-i_acc_x) : AW'(i_acc_x);
                r_mag[1] <= i_acc_y[AW-1] ? AW'(-i_acc_y) : AW'(i_acc_y);
                r_mag[2] <= i_acc_z[AW-1] ? AW'(-i_acc_z) : AW'(i_acc_z);
                r_neg    <= {i_acc_z[AW-1], i_acc_y[AW-1], i_acc_x[AW-1]};
            end
            N_SHIFT: begin
                if (m[AW-1:30] != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end else if (!m[29]) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] << 1;
                    end
                end else begin
                    r_k   <= 2'd0;
                    r_sum <= '0;
                end
            end
            N_SQ: begin
                r_sum <= r_sum + 62'(sq);
                r_k   <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_rad <= r_sum + 62'(sq);
                    r_res <= '0;
                    r_bit <= 63'(1) << 62;
                end
            end
            N_SQRT: begin
                if ({2'b0, r_rad} >= trial) begin
                    r_rad <= 62'({2'b0, r_rad} - trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= 2'd0;
            end
            N_DSET: begin
                r_rem <= 47'({r_mag[r_k][29:0], 15'd0}) + 47'(r_res[31:0]);
                r_dsh <= {r_res[31:0], 16'd0};
                r_q   <= '0;
                r_i   <= 4'd15;
            end
            N_DIV: begin
                if (ge) begin
                    r_rem <= 47'({1'b0, r_rem} - r_dsh);
                end
                r_q   <= qn;
                r_dsh <= r_dsh >> 1;
                r_i   <= r_i - 4'd1;
                if (r_i == 4'd0) begin
                    r_out[r_k] <= r_neg[r_k] ? -$signed(qc) : $signed(qc);
                    r_k        <= r_k + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_norm_x = r_out[0];
    assign o_norm_y = r_out[1];
    assign o_norm_z = r_out[2];

endmodule

// ===== rtl/core/vna_back.sv =====
// Back end: vertex and accumulator memories and the request sequencer.
module vna_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vna_pkg::t_req                    i_req,
    input  logic                             i_req_valid,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [vna_pkg::OUT_W-1:0] o_norm_z
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FACE  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_RDW   = 3'd5;
    localparam logic [2:0] S_NORM  = 3'd6;

    localparam int AW = vna_pkg::ACC_W;
    localparam int PW = vna_pkg::POS_W;
    localparam int VW = vna_pkg::VREC_W;
    localparam int RW = vna_pkg::AREC_W;
    localparam int DW = vna_pkg::ADDR_W;

    logic [VW-1:0] vmem [vna_pkg::MAX_VERTS];
    logic [RW-1:0] amem [vna_pkg::MAX_VERTS];

    logic [2:0]                   r_state;
    logic [DW-1:0]                r_clr;
    vna_pkg::t_req                r_req;
    logic [1:0]                   r_k;
    logic [2:0]                   r_j;
    logic                         r_ph;
    logic [VW-1:0]                r_p [3];
    logic signed [vna_pkg::N_W-1:0] r_n [3];
    logic [VW-1:0]                r_vrd;
    logic [RW-1:0]                r_ard;
    logic                         r_valid;
    logic [1:0]                   r_status;
    logic signed [vna_pkg::OUT_W-1:0] r_nx;
    logic signed [vna_pkg::OUT_W-1:0] r_ny;
    logic signed [vna_pkg::OUT_W-1:0] r_nz;

    logic          v_we;
    logic [DW-1:0] v_waddr;
    logic [VW-1:0] v_wdata;
    logic          v_re;
    logic [DW-1:0] v_raddr;
    logic          a_we;
    logic [DW-1:0] a_waddr;
    logic [RW-1:0] a_wdata;
    logic          a_re;
    logic [DW-1:0] a_raddr;

    logic          emit;
    logic [1:0]    emit_st;
    logic          emit_norm;
    logic          norm_start;
    logic          norm_done;
    logic signed [vna_pkg::OUT_W-1:0] norm_x;
    logic signed [vna_pkg::OUT_W-1:0] norm_y;
    logic signed [vna_pkg::OUT_W-1:0] norm_z;

    logic [DW-1:0]           corner;
    logic signed [PW-1:0]    px [3][3];
    logic signed [PW:0]      dt [3];
    logic signed [PW:0]      db [3];
    logic signed [PW:0]      mul_a;
    logic signed [PW:0]      mul_b;
    logic signed [2*PW+1:0]  prod;
    logic                    all_loaded;

    // Corner address, edge vectors and the shared multiplier
    always_comb begin
        case (r_k)
            2'd0:    corner = vna_pkg::to_addr(r_req.ia);
            2'd1:    corner = vna_pkg::to_addr(r_req.ib);
            default: corner = vna_pkg::to_addr(r_req.ic);
        endcase
        for (int v = 0; v < 3; v++) begin
            px[v][0] = r_p[v][3*PW-1:2*PW];
            px[v][1] = r_p[v][2*PW-1:PW];
            px[v][2] = r_p[v][PW-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            dt[k] = (PW+1)'(px[1][k]) - (PW+1)'(px[0][k]);
            db[k] = (PW+1)'(px[2][k]) - (PW+1)'(px[0][k]);
        end
        case (r_j)
            3'd0:    begin mul_a = dt[1]; mul_b = db[2]; end
            3'd1:    begin mul_a = dt[2]; mul_b = db[1]; end
            3'd2:    begin mul_a = dt[2]; mul_b = db[0]; end
            3'd3:    begin mul_a = dt[0]; mul_b = db[2]; end
            3'd4:    begin mul_a = dt[0]; mul_b = db[1]; end
            default: begin mul_a = dt[1]; mul_b = db[0]; end
        endcase
        prod       = mul_a * mul_b;
        all_loaded = r_p[0][VW-1] && r_p[1][VW-1] && r_vrd[VW-1];
    end

    // Memory port controls and result selection
    always_comb begin
        v_we       = 1'b0;
        v_waddr    = vna_pkg::to_addr(i_req.ia);
        v_wdata    = {1'b1, i_req.x, i_req.y, i_req.z};
        v_re       = 1'b0;
        v_raddr    = corner;
        a_we       = 1'b0;
        a_waddr    = vna_pkg::to_addr(i_req.ia);
        a_wdata    = '0;
        a_re       = 1'b0;
        a_raddr    = corner;
        o_pop      = 1'b0;
        emit       = 1'b0;
        emit_st    = vna_pkg::ST_OK;
        emit_norm  = 1'b0;
        norm_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
                v_wdata = '0;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_pop = 1'b1;
                    case (i_req.op)
                        vna_pkg::OP_LOAD: begin
                            v_we = i_req.ok_a;
                            a_we = i_req.ok_a;
                            emit = 1'b1;
                        end
                        vna_pkg::OP_FACE: begin
                            if (!(i_req.ok_a && i_req.ok_b && i_req.ok_c)) begin
                                emit    = 1'b1;
                                emit_st = vna_pkg::ST_DROP;
                            end
                        end
                        vna_pkg::OP_READ: begin
                            v_raddr = vna_pkg::to_addr(i_req.ia);
                            a_raddr = vna_pkg::to_addr(i_req.ia);
                            v_re    = i_req.ok_a;
                            a_re    = i_req.ok_a;
                            if (!i_req.ok_a) begin
                                emit    = 1'b1;
                                emit_st = vna_pkg::ST_ZERO;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_FACE: begin
                v_re = (r_k != 2'd3);
                if ((r_k == 2'd3) && !all_loaded) begin
                    emit    = 1'b1;
                    emit_st = vna_pkg::ST_DROP;
                end
            end
            S_ACC: begin
                a_re    = !r_ph;
                a_we    = r_ph;
                a_waddr = corner;
                a_wdata = {vna_pkg::sat_add($signed(r_ard[3*AW-1:2*AW]), r_n[0]),
                           vna_pkg::sat_add($signed(r_ard[2*AW-1:AW]), r_n[1]),
                           vna_pkg::sat_add($signed(r_ard[AW-1:0]), r_n[2])};
                emit    = r_ph && (r_k == 2'd2);
            end
            S_RDW: begin
                if (!r_vrd[VW-1] || (r_ard == '0)) begin
                    emit    = 1'b1;
                    emit_st = vna_pkg::ST_ZERO;
                end else begin
                    norm_start = 1'b1;
                end
            end
            S_NORM: begin
                emit      = norm_done;
                emit_norm = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Memories with registered reads
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re) begin
            r_vrd <= vmem[v_raddr];
        end
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
        if (a_re) begin
            r_ard <= amem[a_raddr];
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == DW'(vna_pkg::MAX_VERTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid && !emit) begin
                        r_state <= (i_req.op == vna_pkg::OP_FACE) ? S_FACE : S_RDW;
                    end
                end
                S_FACE: begin
                    if (r_k == 2'd3) begin
                        r_state <= all_loaded ? S_MUL : S_IDLE;
                    end
                end
                S_MUL: begin
                    if (r_j == 3'd5) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDW: begin
                    r_state <= emit ? S_IDLE : S_NORM;
                end
                S_NORM: begin
                    if (norm_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Sequencer datapath and result register
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req <= i_req;
                r_k   <= 2'd0;
            end
            S_FACE: begin
                if (r_k != 2'd0) begin
                    r_p[r_k - 2'd1] <= r_vrd;
                end
                r_k <= r_k + 2'd1;
                r_j <= 3'd0;
            end
            S_MUL: begin
                r_n[r_j[2:1]] <= r_j[0] ? r_n[r_j[2:1]] - vna_pkg::N_W'(prod)
                                         : vna_pkg::N_W'(prod);
                r_j  <= r_j + 3'd1;
                r_k  <= 2'd0;
                r_ph <= 1'b0;
            end
            S_ACC: begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    r_k <= r_k + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_status <= emit_st;
            r_nx     <= emit_norm ? norm_x : '0;
            r_ny     <= emit_norm ? norm_y : '0;
            r_nz     <= emit_norm ? norm_z : '0;
        end
    end

    vna_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (norm_start),
        .i_acc_x  ($signed(r_ard[3*AW-1:2*AW])),
        .i_acc_y  ($signed(r_ard[2*AW-1:AW])),
        .i_acc_z  ($signed(r_ard[AW-1:0])),
        .o_done   (norm_done),
        .o_norm_x (norm_x),
        .o_norm_y (norm_y),
        .o_norm_z (norm_z)
    );

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_norm_x = r_nx;
    assign o_norm_y = r_ny;
    assign o_norm_z = r_nz;

endmodule

// ===== test/vertex_normal_accumulator_test.sv =====
// Self-checking testbench for the vertex normal accumulator.
`timescale 1ns / 1ps

module vertex_normal_accumulator_test;
    import vna_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam longint ACC_TOP = 64'sd549755813887;
    localparam longint ACC_BOT = -64'sd549755813888;

    typedef struct {
        logic [1:0]              op;
        logic [IDX_W-1:0]        ia;
        logic [IDX_W-1:0]        ib;
        logic [IDX_W-1:0]        ic;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        bit                      drain;
    } mesh_req_t;

    typedef struct {
        logic [1:0]              status;
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
    } normal_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] i_op = OP_NONE;
    logic [IDX_W-1:0] i_index_a = '0;
    logic [IDX_W-1:0] i_index_b = '0;
    logic [IDX_W-1:0] i_index_c = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic signed [POS_W-1:0] i_pos_z = '0;
    logic busy;
    logic o_valid;
    logic [1:0] o_status;
    logic signed [OUT_W-1:0] o_norm_x;
    logic signed [OUT_W-1:0] o_norm_y;
    logic signed [OUT_W-1:0] o_norm_z;

    vertex_normal_accumulator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_op(i_op),
        .i_index_a(i_index_a), .i_index_b(i_index_b), .i_index_c(i_index_c),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .busy(busy), .o_valid(o_valid), .o_status(o_status),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z)
    );

    // Mirror of the mesh state
    longint mesh_pos [MAX_VERTS][3];
    bit     mesh_loaded [MAX_VERTS];
    longint mesh_acc [MAX_VERTS][3];

    mesh_req_t   pending_reqs[$];
    normal_res_t expected_normals[$];
    int  mismatch_count = 0;
    int  req_total = 0;
    bit  stim_done = 1'b0;
    bit  all_drained = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat40(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_TOP) return ACC_TOP;
        if (s < ACC_BOT) return ACC_BOT;
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Apply one request to the mirror and return its result
    function automatic normal_res_t predict_normal(mesh_req_t r);
        normal_res_t res;
        longint t[3];
        longint b[3];
        longint n[3];
        longint a[3];
        longint unsigned mag[3];
        longint unsigned m, sum, len, q;
        int top;
        int corner[3];
        res = '{ST_OK, 16'sd0, 16'sd0, 16'sd0};
        case (r.op)
            OP_LOAD: begin
                mesh_pos[r.ia][0] = r.x;
                mesh_pos[r.ia][1] = r.y;
                mesh_pos[r.ia][2] = r.z;
                mesh_loaded[r.ia] = 1'b1;
                for (int k = 0; k < 3; k++) mesh_acc[r.ia][k] = 0;
            end
            OP_FACE: begin
                if (!mesh_loaded[r.ia] || !mesh_loaded[r.ib] || !mesh_loaded[r.ic]) begin
                    res.status = ST_DROP;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        t[k] = mesh_pos[r.ib][k] - mesh_pos[r.ia][k];
                        b[k] = mesh_pos[r.ic][k] - mesh_pos[r.ia][k];
                    end
                    n[0] = t[1] * b[2] - t[2] * b[1];
                    n[1] = t[2] * b[0] - t[0] * b[2];
                    n[2] = t[0] * b[1] - t[1] * b[0];
                    corner = '{int'(r.ia), int'(r.ib), int'(r.ic)};
                    foreach (corner[c])
                        for (int k = 0; k < 3; k++)
                            mesh_acc[corner[c]][k] = sat40(mesh_acc[corner[c]][k], n[k]);
                end
            end
            OP_READ: begin
                m = 0;
                for (int k = 0; k < 3; k++) begin
                    a[k] = mesh_acc[r.ia][k];
                    mag[k] = a[k] < 0 ? longint'(-a[k]) : longint'(a[k]);
                    if (mag[k] > m) m = mag[k];
                end
                if (m == 0) begin
                    res.status = ST_ZERO;
                end else begin
                    top = 0;
                    while (top < 63 && (m >> (top + 1)) != 0) top++;
                    sum = 0;
                    for (int k = 0; k < 3; k++) begin
                        if (top > 29) mag[k] = mag[k] >> (top - 29);
                        else mag[k] = mag[k] << (29 - top);
                        sum += mag[k] * mag[k];
                    end
                    len = int_sqrt(sum);
                    for (int k = 0; k < 3; k++) begin
                        q = (mag[k] * 2 * ONE_Q14 + len) / (2 * len);
                        if (q > ONE_Q14) q = ONE_Q14;
                        n[k] = a[k] < 0 ? -longint'(q) : longint'(q);
                    end
                    res.nx = n[0][OUT_W-1:0];
                    res.ny = n[1][OUT_W-1:0];
                    res.nz = n[2][OUT_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_req(input logic [1:0] op, input int ia, input int ib, input int ic,
                             input int x, input int y, input int z, input bit drain = 1'b0);
        mesh_req_t r;
        r.op = op;
        r.ia = ia[IDX_W-1:0];
        r.ib = ib[IDX_W-1:0];
        r.ic = ic[IDX_W-1:0];
        r.x = x[POS_W-1:0];
        r.y = y[POS_W-1:0];
        r.z = z[POS_W-1:0];
        r.drain = drain;
        pending_reqs.push_back(r);
        req_total++;
    endtask

    function automatic int rand_pos();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 600) - 300;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    // Driver: bursts of requests separated by random gaps
    int  sent_cnt = 0;
    int  done_cnt = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    always @(posedge i_clk) begin : driver
        bit go;
        mesh_req_t r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (o_valid) done_cnt++;
            go = start;
            if (start && !busy) begin
                expected_normals.push_back(predict_normal(pending_reqs.pop_front()));
                sent_cnt++;
                go = 1'b0;
                if (burst_left > 0) burst_left--;
            end
            if (!go) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain && done_cnt != sent_cnt)) begin
                    r = pending_reqs[0];
                    go = 1'b1;
                    i_op <= r.op;
                    i_index_a <= r.ia;
                    i_index_b <= r.ib;
                    i_index_c <= r.ic;
                    i_pos_x <= r.x;
                    i_pos_y <= r.y;
                    i_pos_z <= r.z;
                end
            end
            start <= go;
            all_drained <= stim_done && pending_reqs.size() == 0 && !go &&
                           done_cnt == sent_cnt;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin : monitor
        normal_res_t want;
        if (i_rst_n && o_valid) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = expected_normals.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_norm_x !== want.nx) report_mismatch("norm_x", o_norm_x, want.nx);
                if (o_norm_y !== want.ny) report_mismatch("norm_y", o_norm_y, want.ny);
                if (o_norm_z !== want.nz) report_mismatch("norm_z", o_norm_z, want.nz);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int pool[16];
        int p, rep;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each op, drops, zero normals, degenerate faces
        queue_req(OP_LOAD, 0, 0, 0, 0, 0, 0);
        queue_req(OP_LOAD, 1, 0, 0, 32767, 0, 0);
        queue_req(OP_LOAD, 2, 0, 0, 0, 32767, 0);
        queue_req(OP_FACE, 0, 1, 2, 0, 0, 0);
        queue_req(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_req(OP_READ, 1, 0, 0, 0, 0, 0);
        queue_req(OP_LOAD, 1023, 1023, 1023, -32768, -32768, -32768);
        queue_req(OP_LOAD, 512, 0, 0, 32767, -32768, 32767);
        queue_req(OP_LOAD, 341, 682, 682, 21845, 21845, -21846);
        queue_req(OP_FACE, 1023, 512, 341, 0, 0, 0);
        queue_req(OP_READ, 1023, 0, 0, 0, 0, 0);
        queue_req(OP_READ, 512, 0, 0, 0, 0, 0);
        queue_req(OP_FACE, 0, 0, 1, 0, 0, 0);
        queue_req(OP_FACE, 0, 1, 5, 0, 0, 0);
        queue_req(OP_FACE, 682, 0, 1, 0, 0, 0);
        queue_req(OP_READ, 5, 0, 0, 0, 0, 0);
        queue_req(OP_READ, 2, 0, 0, 0, 0, 0, 1'b1);
        queue_req(OP_NONE, 1023, 1023, 1023, -1, -1, -1);
        queue_req(OP_LOAD, 0, 0, 0, 1, -1, 256);
        queue_req(OP_READ, 0, 0, 0, 0, 0, 0);

        // Random: small working sets of vertices, with saturation runs
        while (req_total < 1400) begin
            foreach (pool[k]) pool[k] = $urandom_range(0, 1023);
            foreach (pool[k]) queue_req(OP_LOAD, pool[k], $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), rand_pos(), rand_pos(),
                                        rand_pos());
            if ($urandom_range(0, 3) == 0) begin
                queue_req(OP_LOAD, pool[0], 0, 0, -32768, -32768, -32768);
                queue_req(OP_LOAD, pool[1], 0, 0, 32767, -32768, 32767);
                queue_req(OP_LOAD, pool[2], 0, 0, -32768, 32767, 32767);
                rep = $urandom_range(130, 170);
                repeat (rep) queue_req(OP_FACE, pool[0], pool[1], pool[2], 0, 0, 0);
                for (int k = 0; k < 3; k++) queue_req(OP_READ, pool[k], 0, 0, 0, 0, 0);
            end
            repeat ($urandom_range(40, 120)) begin
                p = $urandom_range(0, 99);
                if (p < 15) begin
                    queue_req(OP_LOAD, pool[$urandom_range(0, 15)], $urandom_range(0, 1023),
                              $urandom_range(0, 1023), rand_pos(), rand_pos(), rand_pos());
                end else if (p < 60) begin
                    queue_req(OP_FACE, pool[$urandom_range(0, 15)], pool[$urandom_range(0, 15)],
                              ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                                           : pool[$urandom_range(0, 15)],
                              rand_pos(), rand_pos(), rand_pos());
                end else if (p < 94) begin
                    queue_req(OP_READ, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                                    : pool[$urandom_range(0, 15)],
                              $urandom_range(0, 1023), $urandom_range(0, 1023),
                              rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 30) == 0);
                end else begin
                    queue_req(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), rand_pos(), rand_pos(), rand_pos());
                end
            end
        end
        stim_done = 1'b1;

        // Drain, then allow for stray results
        wait (all_drained);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_normals.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
